// ===== rtl/rac_pkg.sv =====
// Shared types and constants for the room alarm controller.
`default_nettype none

package rac_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ARM     = 2'd1,
    OP_DISARM  = 2'd2,
    OP_SILENCE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REASON_NONE   = 3'd0,
    REASON_SENSOR = 3'd1,
    REASON_TEMP   = 3'd2,
    REASON_HUMID  = 3'd3,
    REASON_DOOR   = 3'd4,
    REASON_MOTION = 3'd5
  } reason_t;

  typedef enum logic [2:0] {
    CFG_TEMP_LOW   = 3'd0,
    CFG_TEMP_HIGH  = 3'd1,
    CFG_HUMID_LOW  = 3'd2,
    CFG_HUMID_HIGH = 3'd3,
    CFG_MOTION_HOLD = 3'd4
  } cfg_idx_t;

  localparam int TEMP_W  = 12;
  localparam int HUMID_W = 10;
  localparam int HOLD_W  = 22;
  localparam int NOW_W   = 32;
  localparam int CFG_W   = 22;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST   = 12'sd100;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST  = 12'sd350;
  localparam logic [HUMID_W-1:0]       HUMID_LOW_RST  = 10'd200;
  localparam logic [HUMID_W-1:0]       HUMID_HIGH_RST = 10'd800;
  localparam logic [HOLD_W-1:0]        HOLD_RST       = 22'd10000;

  typedef struct packed {
    op_t                       operation;
    logic [NOW_W-1:0]          now_ms;
    logic signed [TEMP_W-1:0]  temperature;
    logic [HUMID_W-1:0]        humidity;
    logic                      sensor_ok;
    logic                      motion_seen;
    logic                      door_opened;
  } item_t;

  typedef struct packed {
    logic    armed;
    logic    active;
    logic    silenced;
    reason_t reason;
    logic    fault;
    logic    hold_valid;
  } alarm_state_t;

  typedef struct packed {
    logic    armed;
    logic    alarm_active;
    logic    alarm_silenced;
    reason_t alarm_reason;
    logic    siren_on;
    logic    light_on;
    logic    sensor_fault;
    logic    new_alarm;
  } result_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic [HUMID_W-1:0]       humid_low;
    logic [HUMID_W-1:0]       humid_high;
    logic [HOLD_W-1:0]        hold_ms;
  } limits_t;

endpackage

`default_nettype wire

// ===== rtl/rac_eval.sv =====
// Next-state and result logic for one item of the room alarm controller.
`default_nettype none

module rac_eval #(
  parameter int TIME_BITS = 32
) (
  input  wire rac_pkg::item_t        item,
  input  wire rac_pkg::limits_t      limits,
  input  wire rac_pkg::alarm_state_t st,
  input  wire [TIME_BITS-1:0]        deadline,
  output rac_pkg::alarm_state_t      st_nxt,
  output logic [TIME_BITS-1:0]       deadline_nxt,
  output rac_pkg::result_t           res
);

  logic [63:0]          now_wide;
  logic [63:0]          hold_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] hold_t;
  logic [TIME_BITS-1:0] remain;
  logic                 hold_running;
  logic                 raised;
  rac_pkg::reason_t     reason;

  assign now_wide  = {{(64-rac_pkg::NOW_W){1'b0}}, item.now_ms};
  assign hold_wide = {{(64-rac_pkg::HOLD_W){1'b0}}, limits.hold_ms};
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign hold_t    = hold_wide[TIME_BITS-1:0];

  always_comb begin
    st_nxt       = st;
    deadline_nxt = deadline;
    remain       = '0;
    hold_running = 1'b0;
    raised       = 1'b0;
    reason       = rac_pkg::REASON_NONE;
    unique case (item.operation)
      rac_pkg::OP_SAMPLE: begin
        st_nxt.fault = !item.sensor_ok;
        if (st.armed && item.motion_seen) begin
          deadline_nxt      = now_t + hold_t;
          st_nxt.hold_valid = 1'b1;
        end
        if (st_nxt.hold_valid) begin
          // hold runs while the wrapped distance to the deadline is positive
          remain       = deadline_nxt - now_t;
          hold_running = (remain != '0) && !remain[TIME_BITS-1];
          if (!hold_running) begin
            st_nxt.hold_valid = 1'b0;
          end
        end

        priority if (!item.sensor_ok) begin
          reason = rac_pkg::REASON_SENSOR;
        end else if ($signed(item.temperature) < $signed(limits.temp_low) ||
                     $signed(item.temperature) > $signed(limits.temp_high)) begin
          reason = rac_pkg::REASON_TEMP;
        end else if (item.humidity < limits.humid_low ||
                     item.humidity > limits.humid_high) begin
          reason = rac_pkg::REASON_HUMID;
        end else if (st.armed && item.door_opened) begin
          reason = rac_pkg::REASON_DOOR;
        end else if (st.armed && hold_running) begin
          reason = rac_pkg::REASON_MOTION;
        end else begin
          reason = rac_pkg::REASON_NONE;
        end

        if (reason == rac_pkg::REASON_NONE) begin
          st_nxt.active   = 1'b0;
          st_nxt.silenced = 1'b0;
          st_nxt.reason   = rac_pkg::REASON_NONE;
        end else if (!st.active || reason != st.reason) begin
          raised          = (reason != st.reason);
          st_nxt.active   = 1'b1;
          st_nxt.silenced = 1'b0;
          st_nxt.reason   = reason;
        end
      end
      rac_pkg::OP_ARM: begin
        st_nxt.armed = 1'b1;
      end
      rac_pkg::OP_DISARM: begin
        st_nxt.armed      = 1'b0;
        st_nxt.hold_valid = 1'b0;
        st_nxt.active     = 1'b0;
        st_nxt.silenced   = 1'b0;
        st_nxt.reason     = rac_pkg::REASON_NONE;
        deadline_nxt      = '0;
      end
      rac_pkg::OP_SILENCE: begin
        if (st.active) begin
          st_nxt.silenced = 1'b1;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  always_comb begin
    res.armed          = st_nxt.armed;
    res.alarm_active   = st_nxt.active;
    res.alarm_silenced = st_nxt.silenced;
    res.alarm_reason   = st_nxt.reason;
    res.siren_on       = st_nxt.active && !st_nxt.silenced;
    res.light_on       = st_nxt.active;
    res.sensor_fault   = st_nxt.fault;
    res.new_alarm      = raised;
  end

endmodule

`default_nettype wire

// ===== rtl/room_alarm_controller_core.sv =====
// Room alarm controller: input stage, alarm state, result register and config registers.
//
// Usage
//   in_*   : one transfer per item. in_tuser carries the operation (sample, arm,
//            disarm, silence); in_tdata carries the sample fields, ignored for
//            operator events.
//   out_*  : exactly one result transfer per input transfer, in order.
//   cfg_*  : write-only register port (limits and motion hold time), written
//            whenever cfg_we is high; write only while no item is in flight.
// Timing
//   An accepted item is held in the input register, evaluated against the
//   alarm state and lands in the result register, from which it is offered.
//   One item per cycle is sustained while out_tready stays high; the alarm
//   state register is updated together with the result register.
// Reset
//   rst_n low clears both stages, the alarm state (disarmed, no alarm, no
//   motion hold, no fault) and restores the default limits.
// Back-pressure
//   With out_tready low the result is held; the input register still takes one
//   more item, then in_tready drops until the result is taken.
`default_nettype none

module room_alarm_controller_core #(
  parameter int TIME_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: now_ms[31:0], temperature[43:32], humidity[53:44],
  //           sensor_ok[54], motion_seen[55], door_opened[56], zero pad
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [63:0]  in_tdata,
  input  wire [1:0]   in_tuser,   // operation[1:0]
  // out_tdata: armed[0], alarm_active[1], alarm_silenced[2], alarm_reason[5:3],
  //            siren_on[6], light_on[7], sensor_fault[8], new_alarm[9], zero pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,
  input  wire         cfg_we,
  input  wire [2:0]   cfg_index,
  input  wire [21:0]  cfg_wdata
);

  logic                  in_valid_r;
  rac_pkg::item_t        in_item_r;
  logic                  out_valid_r;
  logic [15:0]           out_data_r;
  rac_pkg::alarm_state_t state_r;
  logic [TIME_BITS-1:0]  deadline_r;
  rac_pkg::limits_t      limits_r;

  rac_pkg::alarm_state_t state_nxt;
  logic [TIME_BITS-1:0]  deadline_nxt;
  rac_pkg::result_t      res;
  rac_pkg::item_t        in_item;
  logic                  advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_item.operation   = rac_pkg::op_t'(in_tuser);
    in_item.now_ms      = in_tdata[31:0];
    in_item.temperature = in_tdata[43:32];
    in_item.humidity    = in_tdata[53:44];
    in_item.sensor_ok   = in_tdata[54];
    in_item.motion_seen = in_tdata[55];
    in_item.door_opened = in_tdata[56];
  end

  rac_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .item         (in_item_r),
    .limits       (limits_r),
    .st           (state_r),
    .deadline     (deadline_r),
    .st_nxt       (state_nxt),
    .deadline_nxt (deadline_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, res.new_alarm, res.sensor_fault, res.light_on, res.siren_on,
                     res.alarm_reason, res.alarm_silenced, res.alarm_active, res.armed};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= '{armed: 1'b0, active: 1'b0, silenced: 1'b0,
                      reason: rac_pkg::REASON_NONE, fault: 1'b0, hold_valid: 1'b0};
      deadline_r <= '0;
    end else if (advance) begin
      state_r    <= state_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.temp_low   <= rac_pkg::TEMP_LOW_RST;
      limits_r.temp_high  <= rac_pkg::TEMP_HIGH_RST;
      limits_r.humid_low  <= rac_pkg::HUMID_LOW_RST;
      limits_r.humid_high <= rac_pkg::HUMID_HIGH_RST;
      limits_r.hold_ms    <= rac_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rac_pkg::CFG_TEMP_LOW:    limits_r.temp_low   <= cfg_wdata[11:0];
        rac_pkg::CFG_TEMP_HIGH:   limits_r.temp_high  <= cfg_wdata[11:0];
        rac_pkg::CFG_HUMID_LOW:   limits_r.humid_low  <= cfg_wdata[9:0];
        rac_pkg::CFG_HUMID_HIGH:  limits_r.humid_high <= cfg_wdata[9:0];
        rac_pkg::CFG_MOTION_HOLD: limits_r.hold_ms    <= cfg_wdata[21:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
